// ===== rtl/core/srpl_pkg.sv =====
// Shared types and constants for the streaming pattern replace-all block.
// Used by srpl_window, srpl_emit and substring_replace_all_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srpl_pkg;

  // character and register widths
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 4;
  localparam int BYTES_W     = 64;
  localparam int CFG_IDX_W   = 2;

  // window and replacement sizes
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int PAT_LIM   = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int REPL_LIM  = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
  localparam int RUN_DEPTH = (PAT_LIM > REPL_LIM) ? PAT_LIM : REPL_LIM;

  // counts reach one past the window depth before a shift
  localparam int CNT_W  = $clog2(RUN_DEPTH + 2);
  localparam int WIDX_W = (PAT_LIM > 1) ? $clog2(PAT_LIM) : 1;
  localparam int RIDX_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LEN   = 2'd0,
    CFG_PATTERN_BYTES = 2'd1,
    CFG_REPL_LEN      = 2'd2,
    CFG_REPL_BYTES    = 2'd3
  } cfg_reg_e;

  // input item
  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              char_present;
    logic              string_end;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              string_end_out;
    logic              run_last;
  } out_item_t;

  // run of results caused by one input item
  typedef struct packed {
    logic [RUN_DEPTH-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]                 count;
    logic                             bare;
    logic                             ends;
  } run_t;

endpackage

`default_nettype wire

// ===== rtl/core/srpl_window.sv =====
// Match window: holds the recent characters, compares them with the pattern
// and builds the run of results for each accepted item. Depends on srpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srpl_window (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire srpl_pkg::in_item_t            item,
  input  wire logic                          clear,
  input  wire logic [srpl_pkg::CNT_W-1:0]    plen,
  input  wire logic [srpl_pkg::BYTES_W-1:0]  pattern,
  input  wire logic [srpl_pkg::CNT_W-1:0]    rlen,
  input  wire logic [srpl_pkg::BYTES_W-1:0]  repl,
  output srpl_pkg::run_t                     run
);

  logic [srpl_pkg::PAT_LIM-1:0][srpl_pkg::CHAR_W-1:0] window;
  logic [srpl_pkg::PAT_LIM-1:0][srpl_pkg::CHAR_W-1:0] window_next;
  logic [srpl_pkg::CNT_W-1:0]                         count;
  logic [srpl_pkg::CNT_W-1:0]                         count_next;

  logic [srpl_pkg::PAT_LIM-1:0][srpl_pkg::CHAR_W-1:0] wn;
  logic [srpl_pkg::PAT_LIM-1:0][srpl_pkg::CHAR_W-1:0] ws;
  logic [srpl_pkg::CNT_W-1:0]                         wcnt;
  logic [srpl_pkg::CNT_W-1:0]                         cnt1;
  logic                                               full;
  logic                                               match;

  // append the new character and compare with the pattern
  always_comb begin
    wcnt = (count > plen) ? plen : count;
    wn   = window;
    if (item.char_present && (wcnt < srpl_pkg::CNT_W'(srpl_pkg::PAT_LIM))) begin
      wn[wcnt[srpl_pkg::WIDX_W-1:0]] = item.char_in;
    end
    cnt1 = wcnt + srpl_pkg::CNT_W'(1);
    full = (cnt1 >= plen);
    match = 1'b1;
    for (int i = 0; i < srpl_pkg::PAT_LIM; i++) begin
      if ((srpl_pkg::CNT_W'(i) < plen) && (wn[i] != pattern[8*i +: 8])) begin
        match = 1'b0;
      end
    end
    // window with the oldest character shifted out
    ws = wn;
    for (int i = 0; i < srpl_pkg::PAT_LIM - 1; i++) begin
      ws[i] = wn[i+1];
    end
  end

  // pick the run source and the next window state
  always_comb begin
    run         = '0;
    run.ends    = item.string_end;
    window_next = window;
    count_next  = wcnt;
    if (item.char_present) begin
      if (plen == '0) begin
        // pass through
        run.chars[0] = item.char_in;
        run.count    = srpl_pkg::CNT_W'(1);
      end else if (full && match) begin
        // match: replacement text, window cleared
        for (int i = 0; i < srpl_pkg::RUN_DEPTH; i++) begin
          if (i < srpl_pkg::REPL_LIM) begin
            run.chars[i] = repl[8*i +: 8];
          end
        end
        run.count  = rlen;
        count_next = '0;
      end else if (full) begin
        // mismatch: oldest character out, or whole window on string end
        for (int i = 0; i < srpl_pkg::PAT_LIM; i++) begin
          run.chars[i] = wn[i];
        end
        run.count   = item.string_end ? cnt1 : srpl_pkg::CNT_W'(1);
        window_next = ws;
        count_next  = cnt1 - srpl_pkg::CNT_W'(1);
      end else begin
        // window still filling
        for (int i = 0; i < srpl_pkg::PAT_LIM; i++) begin
          run.chars[i] = wn[i];
        end
        run.count   = item.string_end ? cnt1 : '0;
        window_next = wn;
        count_next  = cnt1;
      end
    end else begin
      // bare item: flush only
      for (int i = 0; i < srpl_pkg::PAT_LIM; i++) begin
        run.chars[i] = window[i];
      end
      run.count = item.string_end ? wcnt : '0;
    end
    if (item.string_end) begin
      count_next = '0;
      if (run.count == '0) begin
        run.count = srpl_pkg::CNT_W'(1);
        run.bare  = 1'b1;
      end
    end
  end

  // window count, cleared by a pattern length write
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // window characters
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/srpl_emit.sv =====
// Run buffer: holds the results of one item and hands them out one per cycle
// while result_stall is low. Depends on srpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srpl_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire srpl_pkg::run_t     run_in,
  input  wire logic               result_stall,
  output srpl_pkg::out_item_t     result,
  output logic                    result_valid,
  output logic                    free
);

  srpl_pkg::run_t               run;
  logic [srpl_pkg::RIDX_W-1:0]  idx;
  logic                         busy;
  logic                         last;
  logic                         take;

  // current entry and handshake
  always_comb begin
    last   = (srpl_pkg::CNT_W'(idx) == (run.count - srpl_pkg::CNT_W'(1)));
    take   = busy && !result_stall;
    free   = !busy || (take && last);
    result_valid          = busy;
    result.char_out       = run.bare ? '0 : run.chars[idx];
    result.char_valid     = !run.bare;
    result.string_end_out = run.ends && last;
    result.run_last       = last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + srpl_pkg::RIDX_W'(1);
      end
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/substring_replace_all_top.sv =====
// Streaming pattern replace-all. One byte per item, with an end-of-string mark.
// Every leftmost, non-overlapping occurrence of the pattern (pattern_len bytes,
// up to 8) is replaced by repl_len bytes of repl_bytes; unmatched characters
// come out in order, and the string end flushes the window and marks the last
// result (a bare result with char_valid low if no character carries it).
// An item is taken into the window and its results are loaded into the run
// buffer in the same cycle; they appear in the cycle after and leave one per
// cycle while result_stall is low. With zero or one result per item the block
// runs at one item per cycle while result_stall is low; an item with more
// results holds the input until the run buffer that serializes them is free.
// Configure only while idle; a pattern_len write empties the window.
// Depends on srpl_pkg, srpl_window and srpl_emit.
`timescale 1ns / 1ps
`default_nettype none

module substring_replace_all_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              feed_valid,
  output logic                                   feed_stall,
  input  wire srpl_pkg::in_item_t                feed,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output srpl_pkg::out_item_t                    result,
  input  wire logic                              cfg_we,
  input  wire logic [srpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srpl_pkg::BYTES_W-1:0]      cfg_data
);

  logic [srpl_pkg::LEN_W-1:0]    pattern_len;
  logic [srpl_pkg::BYTES_W-1:0]  pattern_bytes;
  logic [srpl_pkg::LEN_W-1:0]    repl_len;
  logic [srpl_pkg::BYTES_W-1:0]  repl_bytes;
  logic [srpl_pkg::CNT_W-1:0]    plen;
  logic [srpl_pkg::CNT_W-1:0]    rlen;
  logic                          clear;
  logic                          accept;
  logic                          load;
  logic                          free;
  srpl_pkg::run_t                run;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len   <= '0;
      pattern_bytes <= '0;
      repl_len      <= '0;
      repl_bytes    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srpl_pkg::CFG_PATTERN_LEN:   pattern_len   <= cfg_data[srpl_pkg::LEN_W-1:0];
        srpl_pkg::CFG_PATTERN_BYTES: pattern_bytes <= cfg_data;
        srpl_pkg::CFG_REPL_LEN:      repl_len      <= cfg_data[srpl_pkg::LEN_W-1:0];
        srpl_pkg::CFG_REPL_BYTES:    repl_bytes    <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp lengths to the supported sizes
  always_comb begin
    plen = (pattern_len > srpl_pkg::LEN_W'(srpl_pkg::PAT_LIM))
         ? srpl_pkg::CNT_W'(srpl_pkg::PAT_LIM) : srpl_pkg::CNT_W'(pattern_len);
    rlen = (repl_len > srpl_pkg::LEN_W'(srpl_pkg::REPL_LIM))
         ? srpl_pkg::CNT_W'(srpl_pkg::REPL_LIM) : srpl_pkg::CNT_W'(repl_len);
    clear = cfg_we && (cfg_index == srpl_pkg::CFG_PATTERN_LEN);
  end

  // input handshake
  assign feed_stall = !free;
  assign accept     = feed_valid && !feed_stall;
  assign load       = accept && (run.count != '0);

  srpl_window u_window (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (feed),
    .clear   (clear),
    .plen    (plen),
    .pattern (pattern_bytes),
    .rlen    (rlen),
    .repl    (repl_bytes),
    .run     (run)
  );

  srpl_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .run_in       (run),
    .result_stall (result_stall),
    .result       (result),
    .result_valid (result_valid),
    .free         (free)
  );

`ifndef NO_ASSERTIONS
  // input only waits behind a pending result
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    feed_stall |-> result_valid)
    else $error("input stalled with no pending result");

  // string end only on the last result of a run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.string_end_out) |-> result.run_last)
    else $error("string end before the end of a run");

  // a bare result is an end mark with a zero character
  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.char_valid) |->
      (result.string_end_out && (result.char_out == '0)))
    else $error("bare result without end mark");

  // a run continues after a non-final result is taken
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !result.run_last) |=> result_valid)
    else $error("run ended early");
`endif

endmodule

`default_nettype wire
